[design/met_pkg.sv]
`timescale 1ns / 1ps

package met_pkg;

	// Q8.28 working format
	typedef logic signed [35:0] q_t;
	typedef logic [35:0] mag_t;
	typedef logic [71:0] prod_t;

	localparam int CfgDataW = 32;
	localparam int CfgIdxW = 3;

	localparam logic [10:0] MaxWidth = 11'd1024;
	localparam logic [10:0] MaxHeight = 11'd1024;

	localparam logic [10:0] RstFrameWidth = 11'd900;
	localparam logic [10:0] RstFrameHeight = 11'd560;
	localparam logic signed [31:0] RstCenterReal = 32'shF800_0000;
	localparam logic signed [31:0] RstCenterImag = 32'sh0000_0000;
	localparam logic [30:0] RstPixelStep = 31'h0010_0000;
	localparam logic [15:0] RstIterLimit = 16'd256;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_CENTER_REAL  = 3'd2,
		CFG_CENTER_IMAG  = 3'd3,
		CFG_PIXEL_STEP   = 3'd4,
		CFG_ITER_LIMIT   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic signed [31:0] center_real;
		logic signed [31:0] center_imag;
		logic [30:0] pixel_step;
		logic [15:0] iteration_limit;
	} cfg_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] band;
		logic [15:0] iteration_count;
	} result_t;

	typedef struct packed {
		logic start;
		mag_t a;
		mag_t b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		prod_t prod;
	} mul_rsp_t;

	typedef enum logic [1:0] {
		MPH_IDLE,
		MPH_LO,
		MPH_HI,
		MPH_SUM
	} mul_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_RE,
		ST_MAP_IM,
		ST_ITER,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CROSS,
		ST_FINISH
	} seq_state_t;

endpackage

[design/met_mul.sv]
`timescale 1ns / 1ps

// 36x36 unsigned multiply on one 36x18 multiplier, two partial products.
module met_mul import met_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mul_req_t req,
	output mul_rsp_t rsp
);

	mul_phase_t phase_q, phase_d;
	mag_t a_q, b_q;
	logic [53:0] part_s1;
	prod_t acc_q;
	logic done_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			MPH_IDLE: if (req.start) phase_d = MPH_LO;
			MPH_LO:   phase_d = MPH_HI;
			MPH_HI:   phase_d = MPH_SUM;
			MPH_SUM:  phase_d = MPH_IDLE;
			default:  phase_d = MPH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MPH_IDLE;
			done_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q <= (phase_q == MPH_SUM);
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == MPH_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (phase_q == MPH_LO) part_s1 <= 54'(a_q) * 54'(b_q[17:0]);
		if (phase_q == MPH_HI) begin
			part_s1 <= 54'(a_q) * 54'(b_q[35:18]);
			acc_q <= {18'b0, part_s1};
		end
		if (phase_q == MPH_SUM) acc_q <= acc_q + {part_s1, 18'b0};
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

[design/met_seq.sv]
`timescale 1ns / 1ps

// Sequencer and Q8.28 datapath around the shared multiplier.
module met_seq import met_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input pixel_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data,
	output mul_req_t mreq,
	input mul_rsp_t mrsp
);

	localparam mag_t MagCap = 36'h8_0000_0000;
	localparam logic [7:0] BandLast = 8'd253;
	localparam logic [7:0] BandCycle = 8'd254;
	localparam logic [36:0] EscapeLimit = 37'h0_4000_0000;

	function automatic q_t sat37(input logic signed [36:0] v);
		if (v[36] != v[35]) return v[36] ? q_t'({1'b1, 35'b0}) : q_t'({1'b0, {35{1'b1}}});
		return v[35:0];
	endfunction

	function automatic q_t sat45(input logic signed [44:0] v);
		if (v[44:35] == '0 || v[44:35] == '1) return v[35:0];
		return v[44] ? q_t'({1'b1, 35'b0}) : q_t'({1'b0, {35{1'b1}}});
	endfunction

	function automatic mag_t abs_q(input q_t v);
		q_t n;
		n = -v;
		return v[35] ? mag_t'(n) : mag_t'(v);
	endfunction

	// |a||b| >> 28, capped at 2^35
	function automatic mag_t cap_mag(input prod_t p);
		logic [43:0] m;
		m = p[71:28];
		return (m > {8'b0, MagCap}) ? MagCap : m[35:0];
	endfunction

	function automatic q_t pos_q(input mag_t r);
		return (r == MagCap) ? q_t'({1'b0, {35{1'b1}}}) : $signed(r);
	endfunction

	function automatic q_t neg_q(input mag_t r);
		logic signed [36:0] n;
		n = -$signed({1'b0, r});
		return n[35:0];
	endfunction

	function automatic logic signed [12:0] pix_diff(input logic [9:0] pix,
			input logic [10:0] size);
		return $signed({2'b00, pix, 1'b0}) - $signed({2'b00, size});
	endfunction

	// c = sat(center + floor(p / 2)), p = signed product of step and |d|
	function automatic q_t map_c(input prod_t p, input logic neg,
			input logic signed [31:0] ctr);
		logic signed [43:0] pv;
		logic signed [43:0] half;
		logic signed [44:0] sum;
		pv = neg ? -$signed({2'b00, p[41:0]}) : $signed({2'b00, p[41:0]});
		half = pv >>> 1;
		sum = $signed({{13{ctr[31]}}, ctr}) + $signed({half[43], half});
		return sat45(sum);
	endfunction

	seq_state_t state_q, state_d;
	logic pend_q;
	logic out_valid_q;
	result_t out_q;

	logic [9:0] px_q, py_q;
	q_t cr_q, ci_q, zr_q, zi_q, pri_q;
	mag_t zr2_q, zi2_q;
	logic [15:0] it_q;
	logic [7:0] mod_q;

	logic signed [12:0] d_re, d_im, dabs_re, dabs_im;
	logic [36:0] sum_sq;
	logic cont;
	q_t dbl_pri, diff_sq;
	q_t zr_new, zi_new;
	mag_t r_cap;
	logic load_out;
	logic [7:0] band;

	assign d_re = pix_diff(px_q, cfg.frame_width);
	assign d_im = pix_diff(py_q, cfg.frame_height);
	assign dabs_re = d_re[12] ? -d_re : d_re;
	assign dabs_im = d_im[12] ? -d_im : d_im;

	assign sum_sq = {1'b0, zr2_q} + {1'b0, zi2_q};
	assign cont = (sum_sq <= EscapeLimit) && (it_q < cfg.iteration_limit);
	assign dbl_pri = sat37($signed({pri_q, 1'b0}));
	assign diff_sq = sat37($signed({1'b0, zr2_q}) - $signed({1'b0, zi2_q}));
	assign zi_new = sat37($signed({dbl_pri[35], dbl_pri}) + $signed({ci_q[35], ci_q}));
	assign zr_new = sat37($signed({diff_sq[35], diff_sq}) + $signed({cr_q[35], cr_q}));
	assign r_cap = cap_mag(mrsp.prod);

	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign band = (it_q >= cfg.iteration_limit) ? 8'd0 : mod_q + 8'd1;

	always_comb begin
		state_d = state_q;
		mreq.start = 1'b0;
		mreq.a = '0;
		mreq.b = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MAP_RE;
			end
			ST_MAP_RE: begin
				mreq.start = !pend_q;
				mreq.a = {5'b0, cfg.pixel_step};
				mreq.b = {25'b0, dabs_re[10:0]};
				if (mrsp.done) state_d = ST_MAP_IM;
			end
			ST_MAP_IM: begin
				mreq.start = !pend_q;
				mreq.a = {5'b0, cfg.pixel_step};
				mreq.b = {25'b0, dabs_im[10:0]};
				if (mrsp.done) state_d = ST_ITER;
			end
			ST_ITER: begin
				state_d = cont ? ST_SQ_RE : ST_FINISH;
			end
			ST_SQ_RE: begin
				mreq.start = !pend_q;
				mreq.a = abs_q(zr_q);
				mreq.b = abs_q(zr_q);
				if (mrsp.done) state_d = ST_SQ_IM;
			end
			ST_SQ_IM: begin
				mreq.start = !pend_q;
				mreq.a = abs_q(zi_q);
				mreq.b = abs_q(zi_q);
				if (mrsp.done) state_d = ST_CROSS;
			end
			ST_CROSS: begin
				mreq.start = !pend_q;
				mreq.a = abs_q(zr_q);
				mreq.b = abs_q(zi_q);
				if (mrsp.done) state_d = ST_ITER;
			end
			ST_FINISH: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mreq.start) pend_q <= 1'b1;
			else if (mrsp.done) pend_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			px_q <= in_data.pixel_x;
			py_q <= in_data.pixel_y;
			zr_q <= '0;
			zi_q <= '0;
			zr2_q <= '0;
			zi2_q <= '0;
			pri_q <= '0;
			it_q <= '0;
			mod_q <= '0;
		end
		if (state_q == ST_MAP_RE && mrsp.done)
			cr_q <= map_c(mrsp.prod, d_re[12], cfg.center_real);
		if (state_q == ST_MAP_IM && mrsp.done)
			ci_q <= map_c(mrsp.prod, d_im[12], cfg.center_imag);
		if (state_q == ST_ITER && cont) begin
			zr_q <= zr_new;
			zi_q <= zi_new;
			it_q <= it_q + 16'd1;
			mod_q <= (mod_q == BandLast) ? 8'd0 : mod_q + 8'd1;
		end
		if (state_q == ST_SQ_RE && mrsp.done) zr2_q <= pos_q(r_cap);
		if (state_q == ST_SQ_IM && mrsp.done) zi2_q <= pos_q(r_cap);
		if (state_q == ST_CROSS && mrsp.done)
			pri_q <= (zr_q[35] ^ zi_q[35]) ? neg_q(r_cap) : pos_q(r_cap);
		if (load_out) begin
			out_q.band <= band;
			out_q.iteration_count <= it_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> pend_q)
		else $error("multiplier result with no product outstanding");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (mod_q < BandCycle))
		else $error("band counter out of range");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish step");

	a_accept_starts_map: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MAP_RE))
		else $error("accepted request did not start mapping");

endmodule

[design/mandelbrot_escape_time_pixel_top.sv]
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data   (pixel_x, pixel_y)
// out      out_valid / out_ready  out_data  (band, iteration_count)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (register write)
//
// Per request: a mapping product for c's real part, then its imaginary part, then
//   per iteration three product steps plus one update step; one 36x18 multiplier
//   forms each product in low, high and sum phases and hands it back registered.
// One request at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is taken while
//   the previous result still waits on out_ready; a finished request stalls in
//   its last step only while the result before it is still unread.
// Reset (arst_n low) returns the view registers to their defaults and drops
//   any request in flight; cfg_ready is always high.

module mandelbrot_escape_time_pixel_top import met_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pixel_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg_q;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// Size writes clamp at the view maximum; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= RstFrameWidth;
			cfg_q.frame_height <= RstFrameHeight;
			cfg_q.center_real <= RstCenterReal;
			cfg_q.center_imag <= RstCenterImag;
			cfg_q.pixel_step <= RstPixelStep;
			cfg_q.iteration_limit <= RstIterLimit;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:
					cfg_q.frame_width <= (cfg_data[10:0] > MaxWidth) ? MaxWidth : cfg_data[10:0];
				CFG_FRAME_HEIGHT:
					cfg_q.frame_height <= (cfg_data[10:0] > MaxHeight) ? MaxHeight : cfg_data[10:0];
				CFG_CENTER_REAL: cfg_q.center_real <= $signed(cfg_data[31:0]);
				CFG_CENTER_IMAG: cfg_q.center_imag <= $signed(cfg_data[31:0]);
				CFG_PIXEL_STEP:  cfg_q.pixel_step <= cfg_data[30:0];
				CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Sequencer: maps the pixel to c, then runs z = z^2 + c until escape or limit.
	met_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mreq(mreq),
		.mrsp(mrsp)
	);

	// Shared multiplier used for coordinate mapping, every square and the cross product.
	met_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rsp(mrsp)
	);

endmodule
